FILE: rtl/core/fcr_pkg.sv
// Shared types and constants for the fully connected ReLU layer.
// Holds transaction structs, function codes, register indexes and defaults.
// No dependencies.
`default_nettype none

package fcr_pkg;

    localparam int IN_MAX_DEF     = 256;
    localparam int OUT_MAX_DEF    = 64;
    localparam int DATA_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int VALUE_W = 24;
    localparam int ROW_W   = 8;
    localparam int COL_W   = 6;
    localparam int INDEX_W = 6;
    localparam int FUNC_W  = 2;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 9;
    localparam int IN_CNT_W    = 9;
    localparam int OUT_CNT_W   = 7;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_WEIGHT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_BIAS   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DATA        = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_INPUT_COUNT  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_COUNT = 8'd1;

    localparam logic [IN_CNT_W-1:0]  INPUT_COUNT_RST  = 9'd256;
    localparam logic [OUT_CNT_W-1:0] OUTPUT_COUNT_RST = 7'd64;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [INDEX_W-1:0]        neuron_index;
        logic                      last;
    } out_item_t;

    typedef struct packed {
        logic load_weight;
        logic load_bias;
        logic take_data;
        logic mac_issue;
        logic first;
        logic out_load;
        logic out_last;
    } fcr_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/fully_connected_relu_layer.sv
// Top level of the fully connected ReLU layer: controller plus datapath.
// Depends on fcr_pkg, fcr_ctrl, fcr_datapath and fcr_ram.
// Weight and bias loads are accepted back to back while the layer is idle.
// An activation issues one MAC per neuron through the single shared
// multiplier, then drains the pipeline through ST_DRAIN0 and ST_DRAIN1.
// Closing a vector emits each result through the accumulator/bias read,
// the ReLU stage and the output register handshake, which waits on m_ready.
// Reset clears control state and sets input_count 256, output_count 64;
// weight, bias and accumulator memories are not cleared.
`default_nettype none

module fully_connected_relu_layer #(
    parameter int IN_MAX     = fcr_pkg::IN_MAX_DEF,
    parameter int OUT_MAX    = fcr_pkg::OUT_MAX_DEF,
    parameter int DATA_WIDTH = fcr_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = fcr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire fcr_pkg::in_item_t                s_item,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output fcr_pkg::out_item_t                    m_item,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [fcr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [fcr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int RW = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int CW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;

    fcr_pkg::fcr_cmd_t cmd;
    logic [RW-1:0]     mac_row;
    logic [CW-1:0]     idx;
    logic              out_taken;

    fcr_ctrl #(
        .IN_MAX  (IN_MAX),
        .OUT_MAX (OUT_MAX),
        .RW      (RW),
        .CW      (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_item.func),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_taken (out_taken),
        .cmd       (cmd),
        .mac_row   (mac_row),
        .idx       (idx)
    );

    fcr_datapath #(
        .IN_MAX     (IN_MAX),
        .OUT_MAX    (OUT_MAX),
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .RW         (RW),
        .CW         (CW)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cmd       (cmd),
        .mac_row   (mac_row),
        .idx       (idx),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .out_taken (out_taken)
    );

endmodule

`default_nettype wire

FILE: rtl/core/fcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for weight, bias and accumulator storage; no dependencies.
`default_nettype none

module fcr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                                       aclk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/fcr_ctrl.sv
// Controller for the fully connected ReLU layer: sequencing, counters, config.
// Depends on fcr_pkg; drives fcr_datapath through fcr_cmd_t.
`default_nettype none

module fcr_ctrl #(
    parameter int IN_MAX  = fcr_pkg::IN_MAX_DEF,
    parameter int OUT_MAX = fcr_pkg::OUT_MAX_DEF,
    parameter int RW      = (IN_MAX > 1) ? $clog2(IN_MAX) : 1,
    parameter int CW      = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [fcr_pkg::FUNC_W-1:0]           s_func,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [fcr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [fcr_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                 out_taken,
    output fcr_pkg::fcr_cmd_t                         cmd,
    output logic [RW-1:0]                             mac_row,
    output logic [CW-1:0]                             idx
);

    localparam int EW = RW + 1;
    localparam int OW = CW + 1;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_MAC       = 3'd1;
    localparam logic [2:0] ST_DRAIN0    = 3'd2;
    localparam logic [2:0] ST_DRAIN1    = 3'd3;
    localparam logic [2:0] ST_EMIT_RD   = 3'd4;
    localparam logic [2:0] ST_EMIT_CALC = 3'd5;
    localparam logic [2:0] ST_EMIT_WAIT = 3'd6;

    logic [2:0]                        state_reg, state_next;
    logic [CW-1:0]                     idx_reg, idx_next;
    logic [RW-1:0]                     ec_reg, ec_next;
    logic                              first_reg, first_next;
    logic [fcr_pkg::IN_CNT_W-1:0]      icnt_reg;
    logic [fcr_pkg::OUT_CNT_W-1:0]     ocnt_reg;

    logic [EW-1:0] eff_in;
    logic [OW-1:0] eff_out;
    logic [EW-1:0] ec_plus;
    logic          idx_last;
    logic          accept;

    always_comb begin
        if (icnt_reg == '0) begin
            eff_in = EW'(1);
        end else if (32'(icnt_reg) > IN_MAX) begin
            eff_in = EW'(IN_MAX);
        end else begin
            eff_in = EW'(icnt_reg);
        end
        if (ocnt_reg == '0) begin
            eff_out = OW'(1);
        end else if (32'(ocnt_reg) > OUT_MAX) begin
            eff_out = OW'(OUT_MAX);
        end else begin
            eff_out = OW'(ocnt_reg);
        end
    end

    assign ec_plus  = {1'b0, ec_reg} + EW'(1);
    assign idx_last = (({1'b0, idx_reg} + OW'(1)) == eff_out);
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ec_next    = ec_reg;
        first_next = first_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_func == fcr_pkg::FUNC_DATA) begin
                    first_next = (ec_reg == '0);
                    idx_next   = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                if (idx_last) begin
                    idx_next   = '0;
                    state_next = ST_DRAIN0;
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_DRAIN0: begin
                state_next = ST_DRAIN1;
            end
            ST_DRAIN1: begin
                if (ec_plus >= eff_in) begin
                    ec_next    = '0;
                    state_next = ST_EMIT_RD;
                end else begin
                    ec_next    = ec_plus[RW-1:0];
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_CALC;
            end
            ST_EMIT_CALC: begin
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (out_taken) begin
                    if (idx_last) begin
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            ec_reg    <= '0;
            first_reg <= 1'b0;
            icnt_reg  <= fcr_pkg::INPUT_COUNT_RST;
            ocnt_reg  <= fcr_pkg::OUTPUT_COUNT_RST;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ec_reg    <= ec_next;
            first_reg <= first_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == fcr_pkg::CFG_INPUT_COUNT) begin
                    icnt_reg <= cfg_data[fcr_pkg::IN_CNT_W-1:0];
                end else if (cfg_index == fcr_pkg::CFG_OUTPUT_COUNT) begin
                    ocnt_reg <= cfg_data[fcr_pkg::OUT_CNT_W-1:0];
                end
            end
        end
    end

    always_comb begin
        cmd.load_weight = accept && (s_func == fcr_pkg::FUNC_LOAD_WEIGHT);
        cmd.load_bias   = accept && (s_func == fcr_pkg::FUNC_LOAD_BIAS);
        cmd.take_data   = accept && (s_func == fcr_pkg::FUNC_DATA);
        cmd.mac_issue   = (state_reg == ST_MAC);
        cmd.first       = first_reg;
        cmd.out_load    = (state_reg == ST_EMIT_CALC);
        cmd.out_last    = idx_last;
    end

    assign mac_row = ec_reg;
    assign idx     = idx_reg;

endmodule

`default_nettype wire

FILE: rtl/core/fcr_datapath.sv
// Datapath for the fully connected ReLU layer: memories, shared MAC, output stage.
// Depends on fcr_pkg and fcr_ram; commanded by fcr_ctrl.
`default_nettype none

module fcr_datapath #(
    parameter int IN_MAX     = fcr_pkg::IN_MAX_DEF,
    parameter int OUT_MAX    = fcr_pkg::OUT_MAX_DEF,
    parameter int DATA_WIDTH = fcr_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = fcr_pkg::FRAC_BITS_DEF,
    parameter int RW         = (IN_MAX > 1) ? $clog2(IN_MAX) : 1,
    parameter int CW         = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire fcr_pkg::in_item_t  s_item,
    input  wire fcr_pkg::fcr_cmd_t  cmd,
    input  wire logic [RW-1:0]      mac_row,
    input  wire logic [CW-1:0]      idx,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output fcr_pkg::out_item_t      m_item,
    output logic                    out_taken
);

    localparam int DW = DATA_WIDTH;
    localparam int VW = fcr_pkg::VALUE_W;
    localparam int NW = fcr_pkg::INDEX_W;
    localparam int WD = 1 << (RW + CW);
    localparam int BD = 1 << CW;

    logic                      w_we;
    logic                      b_we;
    logic [DW-1:0]             load_val;
    logic [DW-1:0]             w_rd;
    logic [DW-1:0]             b_rd;
    logic [DW-1:0]             acc_rd;
    logic [DW-1:0]             acc_wdata;

    logic signed [DW-1:0]      act_reg;
    logic                      s1_valid_reg;
    logic [CW-1:0]             s1_idx_reg;
    logic                      s2_valid_reg;
    logic [CW-1:0]             s2_idx_reg;
    logic signed [2*DW-1:0]    prod_reg;
    logic [DW-1:0]             accd_reg;

    logic signed [2*DW-1:0]    shifted;
    logic [DW-1:0]             term;
    logic [DW-1:0]             sum;

    logic                      m_valid_reg;
    fcr_pkg::out_item_t        m_item_reg;

    assign load_val = DW'(s_item.value);
    assign w_we = cmd.load_weight && (32'(s_item.row) < IN_MAX) && (32'(s_item.col) < OUT_MAX);
    assign b_we = cmd.load_bias && (32'(s_item.col) < OUT_MAX);

    fcr_ram #(.WIDTH(DW), .DEPTH(WD)) u_weight_ram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr ({RW'(s_item.row), CW'(s_item.col)}),
        .wdata (load_val),
        .raddr ({mac_row, idx}),
        .rdata (w_rd)
    );

    fcr_ram #(.WIDTH(DW), .DEPTH(BD)) u_bias_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (CW'(s_item.col)),
        .wdata (load_val),
        .raddr (idx),
        .rdata (b_rd)
    );

    fcr_ram #(.WIDTH(DW), .DEPTH(BD)) u_acc_ram (
        .aclk  (aclk),
        .we    (s2_valid_reg),
        .waddr (s2_idx_reg),
        .wdata (acc_wdata),
        .raddr (idx),
        .rdata (acc_rd)
    );

    assign shifted   = prod_reg >>> FRAC_BITS;
    assign term      = shifted[DW-1:0];
    assign acc_wdata = cmd.first ? term : (accd_reg + term);
    assign sum       = acc_rd + b_rd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.mac_issue;
            s2_valid_reg <= s1_valid_reg;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_data) begin
            act_reg <= DW'(s_item.value);
        end
        s1_idx_reg <= idx;
        s2_idx_reg <= s1_idx_reg;
        prod_reg   <= $signed(w_rd) * act_reg;
        accd_reg   <= acc_rd;
        if (cmd.out_load) begin
            m_item_reg.result_value <= sum[DW-1] ? '0 : VW'(sum);
            m_item_reg.neuron_index <= NW'(idx);
            m_item_reg.last         <= cmd.out_last;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign out_taken = m_valid_reg && m_ready;

endmodule

`default_nettype wire

FILE: tb/tb_fully_connected_relu_layer.sv
`timescale 1ns / 1ps
// Self-checking testbench for fully_connected_relu_layer (fixed-point FC layer with ReLU).
// Predicts neuron outputs from its own copy of weights, biases and accumulators.
// Depends on fcr_pkg and the RTL under rtl/core.

module tb_fully_connected_relu_layer;

    localparam int IN_MAX     = fcr_pkg::IN_MAX_DEF;
    localparam int OUT_MAX    = fcr_pkg::OUT_MAX_DEF;
    localparam int FRAC_BITS  = fcr_pkg::FRAC_BITS_DEF;
    localparam int VALUE_W    = fcr_pkg::VALUE_W;
    localparam int ROW_W      = fcr_pkg::ROW_W;
    localparam int COL_W      = fcr_pkg::COL_W;
    localparam int INDEX_W    = fcr_pkg::INDEX_W;
    localparam int CFG_DATA_W = fcr_pkg::CFG_DATA_W;
    localparam int IDLE_WAIT  = 200;
    localparam int LIMIT      = 1000000;

    localparam logic [fcr_pkg::FUNC_W-1:0]      FUNC_RESERVED = 2'd3;
    localparam logic [fcr_pkg::CFG_INDEX_W-1:0] CFG_UNUSED    = 8'd2;

    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    fcr_pkg::in_item_t               s_item    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    fcr_pkg::out_item_t              m_item;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [fcr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]           cfg_data  = '0;

    // predictor state
    logic [fcr_pkg::IN_CNT_W-1:0]  in_count_reg  = fcr_pkg::INPUT_COUNT_RST;
    logic [fcr_pkg::OUT_CNT_W-1:0] out_count_reg = fcr_pkg::OUTPUT_COUNT_RST;
    logic signed [VALUE_W-1:0]     w_mem    [0:IN_MAX*OUT_MAX-1];
    logic [VALUE_W-1:0]            bias_mem [0:OUT_MAX-1];
    logic [VALUE_W-1:0]            acc_mem  [0:OUT_MAX-1];
    int                            elem_cnt = 0;
    fcr_pkg::out_item_t            expected_neurons[$];

    // stimulus-side bookkeeping
    fcr_pkg::in_item_t pending_items[$];
    bit                w_written [0:IN_MAX*OUT_MAX-1];
    bit                b_written [0:OUT_MAX-1];
    int                gen_elem = 0;

    int       burst_left = 0;
    int       gap_left = 0;
    rx_mode_e rx_mode = RX_FREE;
    int       mode_left = 0;
    int       cycle_count = 0;
    int       error_count = 0;

    fully_connected_relu_layer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic int clamp_count(int v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic apply_layer_item(input fcr_pkg::in_item_t it);
        int nout;
        int nin;
        int r;
        logic signed [2*VALUE_W-1:0] prod;
        logic [VALUE_W-1:0] s;
        fcr_pkg::out_item_t o;
        nout = clamp_count(int'(out_count_reg), OUT_MAX);
        nin  = clamp_count(int'(in_count_reg), IN_MAX);
        case (it.func)
            fcr_pkg::FUNC_LOAD_WEIGHT: w_mem[it.row * OUT_MAX + it.col] = it.value;
            fcr_pkg::FUNC_LOAD_BIAS:   bias_mem[it.col] = it.value;
            fcr_pkg::FUNC_DATA: begin
                r = (elem_cnt >= IN_MAX) ? IN_MAX - 1 : elem_cnt;
                for (int i = 0; i < nout; i++) begin
                    prod = w_mem[r * OUT_MAX + i] * it.value;
                    prod = prod >>> FRAC_BITS;
                    acc_mem[i] = (elem_cnt == 0) ? prod[VALUE_W-1:0]
                                                 : acc_mem[i] + prod[VALUE_W-1:0];
                end
                elem_cnt++;
                if (elem_cnt >= nin) begin
                    elem_cnt = 0;
                    for (int i = 0; i < nout; i++) begin
                        s = acc_mem[i] + bias_mem[i];
                        o.result_value = s[VALUE_W-1] ? '0 : s;
                        o.neuron_index = INDEX_W'(i);
                        o.last         = (i == nout - 1);
                        expected_neurons.push_back(o);
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic [VALUE_W-1:0] rand_value();
        int pick;
        int sv;
        pick = $urandom_range(0, 15);
        case (pick)
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'hFFFFFF;
            3: return 24'h000000;
            4, 5, 6, 7, 8, 9: return VALUE_W'($urandom);
            default: begin
                sv = int'($urandom_range(0, 262143)) - 131072;
                return sv[VALUE_W-1:0];
            end
        endcase
    endfunction

    task automatic push_item(input logic [fcr_pkg::FUNC_W-1:0] f, input logic [ROW_W-1:0] r,
                             input logic [COL_W-1:0] c, input logic [VALUE_W-1:0] v);
        fcr_pkg::in_item_t it;
        it.func  = f;
        it.row   = r;
        it.col   = c;
        it.value = v;
        pending_items.push_back(it);
        if (f == fcr_pkg::FUNC_LOAD_WEIGHT) begin
            w_written[r * OUT_MAX + c] = 1'b1;
        end else if (f == fcr_pkg::FUNC_LOAD_BIAS) begin
            b_written[c] = 1'b1;
        end else if (f == fcr_pkg::FUNC_DATA) begin
            gen_elem++;
            if (gen_elem >= clamp_count(int'(in_count_reg), IN_MAX)) gen_elem = 0;
        end
    endtask

    // load any weight or bias this activation will read before sending it
    task automatic queue_activation();
        int r;
        int nout;
        r    = (gen_elem >= IN_MAX) ? IN_MAX - 1 : gen_elem;
        nout = clamp_count(int'(out_count_reg), OUT_MAX);
        for (int i = 0; i < nout; i++)
            if (!w_written[r * OUT_MAX + i])
                push_item(fcr_pkg::FUNC_LOAD_WEIGHT, ROW_W'(r), COL_W'(i), rand_value());
        if (gen_elem + 1 >= clamp_count(int'(in_count_reg), IN_MAX))
            for (int i = 0; i < nout; i++)
                if (!b_written[i])
                    push_item(fcr_pkg::FUNC_LOAD_BIAS, ROW_W'($urandom_range(0, 255)),
                              COL_W'(i), rand_value());
        push_item(fcr_pkg::FUNC_DATA, ROW_W'($urandom_range(0, 255)),
                  COL_W'($urandom_range(0, 63)), rand_value());
    endtask

    task automatic queue_random(input int n);
        int made;
        int pick;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                queue_activation();
                made++;
            end else if (pick < 82) begin
                push_item(fcr_pkg::FUNC_LOAD_WEIGHT, ROW_W'($urandom_range(0, 255)),
                          COL_W'($urandom_range(0, 63)), rand_value());
                made++;
            end else if (pick < 93) begin
                push_item(fcr_pkg::FUNC_LOAD_BIAS, ROW_W'($urandom_range(0, 255)),
                          COL_W'($urandom_range(0, 63)), rand_value());
                made++;
            end else begin
                push_item(FUNC_RESERVED, ROW_W'($urandom_range(0, 255)),
                          COL_W'($urandom_range(0, 63)), VALUE_W'($urandom));
            end
        end
    endtask

    task automatic close_vector();
        while (gen_elem != 0) queue_activation();
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_neurons.size() != 0);
        repeat (IDLE_WAIT) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [fcr_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == fcr_pkg::CFG_INPUT_COUNT) in_count_reg = d;
        else if (idx == fcr_pkg::CFG_OUTPUT_COUNT) out_count_reg = d[fcr_pkg::OUT_CNT_W-1:0];
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_valid && s_ready) apply_layer_item(s_item);
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    s_item  <= pending_items.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each transaction, stall on a changing pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            rx_mode   <= RX_FREE;
            mode_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_neurons.size() == 0) begin
                    $display("%0t: unexpected result: value %0d neuron %0d last %0b",
                             $time, m_item.result_value, m_item.neuron_index, m_item.last);
                    error_count++;
                end else begin
                    if (m_item.result_value !== expected_neurons[0].result_value) begin
                        $display("%0t: result_value expected %0d got %0d", $time,
                                 expected_neurons[0].result_value, m_item.result_value);
                        error_count++;
                    end
                    if (m_item.neuron_index !== expected_neurons[0].neuron_index) begin
                        $display("%0t: neuron_index expected %0d got %0d", $time,
                                 expected_neurons[0].neuron_index, m_item.neuron_index);
                        error_count++;
                    end
                    if (m_item.last !== expected_neurons[0].last) begin
                        $display("%0t: last expected %0b got %0b", $time,
                                 expected_neurons[0].last, m_item.last);
                        error_count++;
                    end
                    void'(expected_neurons.pop_front());
                end
            end
            if (mode_left == 0) begin
                rx_mode   <= rx_mode_e'($urandom_range(0, 3));
                mode_left <= $urandom_range(20, 120);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_FREE:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
                default:   m_ready <= ~m_ready;
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("tb_fully_connected_relu_layer: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        cfg_write(fcr_pkg::CFG_INPUT_COUNT, 9'd2);
        cfg_write(fcr_pkg::CFG_OUTPUT_COUNT, 9'd3);
        push_item(FUNC_RESERVED, 8'hFF, 6'h3F, 24'hFFFFFF);
        push_item(fcr_pkg::FUNC_LOAD_WEIGHT, 8'd0, 6'd0, 24'h7FFFFF);
        push_item(fcr_pkg::FUNC_LOAD_WEIGHT, 8'd0, 6'd1, 24'h800000);
        push_item(fcr_pkg::FUNC_LOAD_WEIGHT, 8'd0, 6'd2, 24'hFFFFFF);
        push_item(fcr_pkg::FUNC_LOAD_WEIGHT, 8'd1, 6'd0, 24'h800000);
        push_item(fcr_pkg::FUNC_LOAD_WEIGHT, 8'd1, 6'd1, 24'h000001);
        push_item(fcr_pkg::FUNC_LOAD_WEIGHT, 8'd1, 6'd2, 24'h010000);
        push_item(fcr_pkg::FUNC_LOAD_BIAS, 8'hAA, 6'd0, 24'h000000);
        push_item(fcr_pkg::FUNC_LOAD_BIAS, 8'h55, 6'd1, 24'h7FFFFF);
        push_item(fcr_pkg::FUNC_LOAD_BIAS, 8'h00, 6'd2, 24'h800000);
        push_item(fcr_pkg::FUNC_DATA, 8'h00, 6'h00, 24'h7FFFFF);
        push_item(fcr_pkg::FUNC_LOAD_WEIGHT, 8'd1, 6'd2, 24'hFFFF00);
        push_item(fcr_pkg::FUNC_DATA, 8'hFF, 6'h3F, 24'h800000);
        push_item(fcr_pkg::FUNC_DATA, 8'hFF, 6'h3F, 24'h000000);
        push_item(fcr_pkg::FUNC_DATA, 8'h5A, 6'h2A, 24'hFFFFFF);
        push_item(fcr_pkg::FUNC_DATA, 8'hA5, 6'h15, 24'h010000);
        wait_drained();

        // hold the partial vector across the count change
        cfg_write(fcr_pkg::CFG_INPUT_COUNT, 9'd1);
        queue_random(20);
        wait_drained();

        cfg_write(fcr_pkg::CFG_INPUT_COUNT, 9'd0);
        cfg_write(fcr_pkg::CFG_OUTPUT_COUNT, 9'd0);
        cfg_write(CFG_UNUSED, 9'h1FF);
        queue_random(12);
        wait_drained();

        // drop the count below a partial vector
        cfg_write(fcr_pkg::CFG_INPUT_COUNT, 9'h1FF);
        cfg_write(fcr_pkg::CFG_OUTPUT_COUNT, 9'd1);
        repeat (10) queue_activation();
        wait_drained();
        cfg_write(fcr_pkg::CFG_INPUT_COUNT, 9'd4);
        queue_activation();
        wait_drained();

        cfg_write(fcr_pkg::CFG_INPUT_COUNT, 9'd1);
        cfg_write(fcr_pkg::CFG_OUTPUT_COUNT, 9'h1FF);
        queue_random(20);
        wait_drained();

        cfg_write(fcr_pkg::CFG_INPUT_COUNT, CFG_DATA_W'($urandom_range(2, 3)));
        cfg_write(fcr_pkg::CFG_OUTPUT_COUNT, CFG_DATA_W'($urandom_range(1, 8)));
        queue_random(12);
        close_vector();
        wait_drained();

        if (expected_neurons.size() != 0) begin
            $display("%0t: %0d results never arrived, next expected value %0d neuron %0d",
                     $time, expected_neurons.size(), expected_neurons[0].result_value,
                     expected_neurons[0].neuron_index);
            error_count++;
        end
        if (error_count == 0)
            $display("tb_fully_connected_relu_layer: done, clean");
        else
            $display("tb_fully_connected_relu_layer: done, errors");
        $finish;
    end

endmodule
